// ----- design/sdp_body_admission_check_core_macros.svh -----
// Assertion helpers for the SDP body admission check.
`ifndef SDP_BODY_ADMISSION_CHECK_CORE_MACROS_SVH
`define SDP_BODY_ADMISSION_CHECK_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define SDPBAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdpbac assertion failed");

`define SDPBAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdpbac assertion failed");

`else

`define SDPBAC_ASSERT_SAME(lbl, ante, cons)

`define SDPBAC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/sdpbac_pkg.sv -----
`default_nettype none

package sdpbac_pkg;

  typedef enum logic [3:0] {
    VERDICT_OK         = 4'd0,
    VERDICT_BODY_LARGE = 4'd1,
    VERDICT_LINES      = 4'd2,
    VERDICT_LINE_LONG  = 4'd3,
    VERDICT_MALFORMED  = 4'd4,
    VERDICT_TOKENS     = 4'd5,
    VERDICT_FORMATS    = 4'd6,
    VERDICT_BAD_NAME   = 4'd7,
    VERDICT_CAPNEG     = 4'd8
  } verdict_t;

  typedef enum logic [2:0] {
    REG_MAX_BODY_BYTES      = 3'd0,
    REG_MAX_LINES           = 3'd1,
    REG_MAX_LINE_BYTES      = 3'd2,
    REG_MAX_TOKENS_PER_LINE = 3'd3,
    REG_MAX_MEDIA_FORMATS   = 3'd4,
    REG_MAX_ATTR_NAME_BYTES = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    NAME_IDLE    = 2'd0,
    NAME_COLLECT = 2'd1,
    NAME_DONE    = 2'd2
  } name_phase_t;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_M  = 8'h6D;

  localparam logic [6:0]  NAME_KEEP      = 7'd6;
  localparam logic [12:0] LINE_LEN_MAX   = 13'h1FFF;
  localparam logic [8:0]  TOKEN_MAX      = 9'h1FF;
  localparam logic [16:0] BODY_COUNT_MAX = 17'h1FFFF;
  localparam logic [10:0] LINE_COUNT_MAX = 11'h7FF;

  localparam int CAPNEG_COUNT = 14;

  localparam logic [47:0] CAPNEG_NAME [CAPNEG_COUNT] = '{
    {16'h0, "acap"}, {16'h0, "tcap"}, {16'h0, "pcfg"}, {16'h0, "acfg"},
    {16'h0, "creq"}, {8'h0, "rmcap"}, {8'h0, "omcap"}, {8'h0, "mfcap"},
    {8'h0, "mscap"}, {16'h0, "lcfg"}, "sescap", {16'h0, "bcap"},
    {16'h0, "ccap"}, {16'h0, "icap"}
  };

  localparam logic [6:0] CAPNEG_LEN [CAPNEG_COUNT] = '{
    7'd4, 7'd4, 7'd4, 7'd4, 7'd4, 7'd5, 7'd5, 7'd5, 7'd5, 7'd4, 7'd6, 7'd4,
    7'd4, 7'd4
  };

  typedef struct packed {
    logic [15:0] max_body_bytes;
    logic [9:0]  max_lines;
    logic [11:0] max_line_bytes;
    logic [7:0]  max_tokens_per_line;
    logic [6:0]  max_media_formats;
    logic [5:0]  max_attr_name_bytes;
  } limits_t;

  typedef struct packed {
    logic [12:0] line_length;
    logic [7:0]  first_char;
    logic        second_is_equals;
    logic [8:0]  token_count;
    logic        inside_token;
    name_phase_t name_phase;
    logic [6:0]  name_length;
    logic        name_has_bad_char;
    logic [47:0] name_prefix;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    line_length:       13'd0,
    first_char:        8'd0,
    second_is_equals:  1'b0,
    token_count:       9'd0,
    inside_token:      1'b0,
    name_phase:        NAME_IDLE,
    name_length:       7'd0,
    name_has_bad_char: 1'b0,
    name_prefix:       48'd0
  };

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        line_end;
    logic        body_large;
    line_state_t line;
  } line_beat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == "-" || c == "_" ||
           c == "." || c == "+";
  endfunction

  function automatic line_state_t line_byte(input line_state_t s, input logic [7:0] c,
                                            input logic [5:0] max_attr);
    line_state_t r;
    logic [7:0] low;
    logic [6:0] name_len;
    r = s;
    low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    name_len = s.name_length + 7'd1;
    if (s.line_length == 13'd0) begin
      r.first_char = c;
    end
    if (s.line_length == 13'd1) begin
      r.second_is_equals = (c == CHAR_EQUALS);
    end
    if (s.line_length >= 13'd2 && s.first_char == CHAR_LOW_A) begin
      if (s.name_phase == NAME_IDLE || s.name_phase == NAME_COLLECT) begin
        if (c == CHAR_COLON) begin
          r.name_phase = NAME_DONE;
        end else begin
          r.name_phase = NAME_COLLECT;
          r.name_length = name_len;
          if (!is_name_char(c)) begin
            r.name_has_bad_char = 1'b1;
          end
          if (name_len <= NAME_KEEP) begin
            r.name_prefix = {s.name_prefix[39:0], low};
          end
          if (name_len > {1'b0, max_attr}) begin
            r.name_phase = NAME_DONE;
          end
        end
      end
    end
    if (s.line_length != LINE_LEN_MAX) begin
      r.line_length = s.line_length + 13'd1;
    end
    if (c == CHAR_SPACE) begin
      r.inside_token = 1'b0;
    end else if (!s.inside_token) begin
      r.inside_token = 1'b1;
      if (s.token_count != TOKEN_MAX) begin
        r.token_count = s.token_count + 9'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sdpbac_scan.sv -----
`default_nettype none

module sdpbac_scan
  import sdpbac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_present,
  input  wire logic       in_last,
  input  wire limits_t    limits,
  output line_beat_t      beat
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_present;
  logic        s1_last;

  line_state_t line;
  line_state_t line_next;
  line_state_t snap;
  logic        held_cr;
  logic        held_cr_next;
  logic [16:0] body_count;
  logic [16:0] body_inc;
  logic [16:0] body_count_next;
  logic        ends;

  always_comb begin
    line_next = line;
    held_cr_next = held_cr;
    snap = line;
    ends = 1'b0;
    body_inc = body_count;
    if (s1_present && body_count != BODY_COUNT_MAX) begin
      body_inc = body_count + 17'd1;
    end
    if (s1_present) begin
      if (s1_byte == CHAR_LF) begin
        held_cr_next = 1'b0;
        snap = line;
        ends = 1'b1;
        line_next = LINE_CLEAR;
      end else begin
        if (held_cr) begin
          line_next = line_byte(line_next, CHAR_CR, limits.max_attr_name_bytes);
        end
        held_cr_next = (s1_byte == CHAR_CR);
        if (s1_byte != CHAR_CR) begin
          line_next = line_byte(line_next, s1_byte, limits.max_attr_name_bytes);
        end
      end
    end
    body_count_next = body_inc;
    if (s1_last) begin
      held_cr_next = 1'b0;
      body_count_next = 17'd0;
      if (!ends) begin
        snap = line_next;
        ends = 1'b1;
      end
      line_next = LINE_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      beat.valid <= 1'b0;
      line <= LINE_CLEAR;
      held_cr <= 1'b0;
      body_count <= 17'd0;
    end else if (advance) begin
      s1_valid <= in_valid;
      beat.valid <= s1_valid;
      if (s1_valid) begin
        line <= line_next;
        held_cr <= held_cr_next;
        body_count <= body_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte <= in_byte;
      s1_present <= in_present;
      s1_last <= in_last;
      beat.last <= s1_last;
      beat.line_end <= ends && (snap.line_length != 13'd0);
      beat.body_large <= body_inc > {1'b0, limits.max_body_bytes};
      beat.line <= snap;
    end
  end

endmodule

`default_nettype wire

// ----- design/sdpbac_judge.sv -----
`default_nettype none

module sdpbac_judge
  import sdpbac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire line_beat_t beat,
  input  wire limits_t    limits,
  input  wire logic       out_ready,
  output logic            advance,
  output logic            out_valid,
  output verdict_t        out_verdict
);

  logic [10:0] line_count;
  logic [10:0] line_count_inc;
  logic [10:0] line_count_next;
  verdict_t    first_error;
  verdict_t    first_error_next;
  verdict_t    judged;
  verdict_t    verdict_next;
  logic        do_judge;

  function automatic logic name_is_capneg(input line_state_t s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CAPNEG_COUNT; i++) begin
      if (s.name_length == CAPNEG_LEN[i] && s.name_prefix == CAPNEG_NAME[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic verdict_t judge_line(input line_state_t s, input logic [10:0] lines,
                                          input limits_t lim);
    verdict_t v;
    v = VERDICT_OK;
    if (lines > {1'b0, lim.max_lines}) begin
      v = VERDICT_LINES;
    end else if (s.line_length < 13'd2 || !s.second_is_equals || !is_letter(s.first_char))
        begin
      v = VERDICT_MALFORMED;
    end else if (s.first_char == CHAR_LOW_A && (s.name_length == 7'd0 ||
                 s.name_length > {1'b0, lim.max_attr_name_bytes} || s.name_has_bad_char))
        begin
      v = VERDICT_BAD_NAME;
    end else if (s.first_char == CHAR_LOW_A && name_is_capneg(s)) begin
      v = VERDICT_CAPNEG;
    end else if (s.line_length > {1'b0, lim.max_line_bytes}) begin
      v = VERDICT_LINE_LONG;
    end else if (s.token_count > {1'b0, lim.max_tokens_per_line}) begin
      v = VERDICT_TOKENS;
    end else if (s.first_char == CHAR_LOW_M &&
                 {1'b0, s.token_count} > 10'd3 + {3'b0, lim.max_media_formats}) begin
      v = VERDICT_FORMATS;
    end
    return v;
  endfunction

  assign advance = !(beat.valid && beat.last && out_valid && !out_ready);

  always_comb begin
    line_count_inc = (line_count != LINE_COUNT_MAX) ? line_count + 11'd1 : line_count;
    judged = judge_line(beat.line, line_count_inc, limits);
    do_judge = beat.line_end && first_error == VERDICT_OK;
    first_error_next = do_judge ? judged : first_error;
    line_count_next = do_judge ? line_count_inc : line_count;
    verdict_next = beat.body_large ? VERDICT_BODY_LARGE : first_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= 11'd0;
      first_error <= VERDICT_OK;
      out_valid <= 1'b0;
    end else begin
      if (advance && beat.valid) begin
        if (beat.last) begin
          line_count <= 11'd0;
          first_error <= VERDICT_OK;
        end else begin
          line_count <= line_count_next;
          first_error <= first_error_next;
        end
      end
      if (advance && beat.valid && beat.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && beat.valid && beat.last) begin
      out_verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/sdp_body_admission_check_core.sv -----
// SDP body admission check.
// The body enters on the s_ stream, one byte per beat in s_tdata. s_tuser
// set means the byte is real; a beat with s_tuser clear adds no byte and
// serves to close an empty body. s_tlast marks the last beat of a body.
// For each body exactly one verdict leaves on the m_ stream, in the low
// four bits of m_tdata, once the last beat has passed through the input
// register, the line scanner and the verdict register, which form a
// three-stage pipeline taking a new beat every cycle unless stalled.
// If the receiver stalls, the verdict waits in the output register and beats
// keep flowing until a second finished body reaches the judging stage;
// only then is s_tready dropped until the waiting verdict is taken.
// Limits are written on the cfg_ port, which is always ready; they should
// be changed only between bodies. Reset restores the default limits and
// clears all body and line state; there is no clearing pass.
`default_nettype none

`include "sdp_body_admission_check_core_macros.svh"

module sdp_body_admission_check_core
  import sdpbac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // body_byte
  input  wire logic        s_tuser,   // byte_present
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // verdict[3:0], zero fill
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  limits_t    limits;
  line_beat_t beat;
  logic       advance;
  verdict_t   verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_body_bytes <= 16'd4096;
      limits.max_lines <= 10'd64;
      limits.max_line_bytes <= 12'd256;
      limits.max_tokens_per_line <= 8'd32;
      limits.max_media_formats <= 7'd16;
      limits.max_attr_name_bytes <= 6'd32;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_BODY_BYTES:      limits.max_body_bytes <= cfg_data;
        REG_MAX_LINES:           limits.max_lines <= cfg_data[9:0];
        REG_MAX_LINE_BYTES:      limits.max_line_bytes <= cfg_data[11:0];
        REG_MAX_TOKENS_PER_LINE: limits.max_tokens_per_line <= cfg_data[7:0];
        REG_MAX_MEDIA_FORMATS:   limits.max_media_formats <= cfg_data[6:0];
        REG_MAX_ATTR_NAME_BYTES: limits.max_attr_name_bytes <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign s_tready = advance;
  assign m_tdata = {4'b0000, verdict};

  sdpbac_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_present (s_tuser),
    .in_last    (s_tlast),
    .limits     (limits),
    .beat       (beat)
  );

  sdpbac_judge u_judge (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .limits      (limits),
    .out_ready   (m_tready),
    .advance     (advance),
    .out_valid   (m_tvalid),
    .out_verdict (verdict)
  );

  `SDPBAC_ASSERT_SAME(a_stall_only_on_blocked_verdict, !s_tready,
                      m_tvalid && !m_tready && beat.valid && beat.last)
  `SDPBAC_ASSERT_SAME(a_verdict_in_range, m_tvalid,
                      m_tdata[7:4] == 4'd0 && m_tdata[3:0] <= 4'd8)
  `SDPBAC_ASSERT_NEXT(a_final_gives_verdict, advance && beat.valid && beat.last,
                      m_tvalid)

endmodule

`default_nettype wire
